// ===== rtl/hflp_pkg.sv =====
// Shared types and constants of the hexadecimal binary32 literal parser.
`timescale 1ns / 1ps

package hflp_pkg;

    // Number of significant mantissa bits kept before the sticky bit takes over.
    localparam int KEEP_BITS = 60;
    localparam int MANT_W    = KEEP_BITS;
    localparam int MSB_W     = $clog2(MANT_W);
    localparam int MBC_W     = 7;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_SIGNED     = 3'd1,
        PH_ZERO       = 3'd2,
        PH_MANT       = 3'd3,
        PH_EXP_START  = 3'd4,
        PH_EXP_SIGNED = 3'd5,
        PH_EXP_DIGITS = 3'd6,
        PH_DECIMAL    = 3'd7
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_DECIMAL   = 2'd2
    } status_t;

    localparam logic [31:0] EXP_SAT  = 32'h8000_0000;
    localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;

    // Complete parse state of one literal.
    typedef struct packed {
        phase_t              phase;
        logic                negative;
        logic [MANT_W-1:0]   mantissa;
        logic [MBC_W-1:0]    mant_bit_cnt;
        logic [31:0]         digit_bit_cnt;
        logic                point_seen;
        logic [31:0]         point_pos;
        logic [31:0]         extra_bit_cnt;
        logic [31:0]         exp_mag;
        logic                exp_neg;
        logic                error_seen;
    } snap_t;

    // Stage 1 result: status, early answers, exponent and leading-one index.
    typedef struct packed {
        status_t             status;
        logic                special;
        logic [31:0]         special_bits;
        logic                sign;
        logic [MANT_W-1:0]   mantissa;
        logic signed [31:0]  exponent;
        logic [MSB_W-1:0]    msb;
    } prep_t;

    // Stage 2 result: mantissa rounded to 24 bits and the exponent of its top bit.
    typedef struct packed {
        status_t             status;
        logic                special;
        logic [31:0]         special_bits;
        logic                sign;
        logic [23:0]         q;
        logic signed [33:0]  top;
    } rnd_t;

endpackage

// ===== rtl/hflp_parse.sv =====
// Character-by-character parser that builds the literal state and hands it on at the end.
`timescale 1ns / 1ps

module hflp_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [7:0]        character,
    input  logic              last,
    output logic              snap_valid,
    output hflp_pkg::snap_t   snap
);

    hflp_pkg::snap_t st_reg;
    hflp_pkg::snap_t st_next;
    hflp_pkg::snap_t snap_reg;
    logic            snap_valid_reg;

    logic            is_hex;
    logic [3:0]      hex_val;
    logic            is_dec;
    logic [35:0]     exp_prod;
    logic [31:0]     exp_mag_digit;

    // Hex digit decode.
    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (character >= "0" && character <= "9")
        begin
            hex_val = 4'(character - 8'h30);
        end
        else if (character >= "A" && character <= "F")
        begin
            hex_val = 4'(character - 8'h37);
        end
        else if (character >= "a" && character <= "f")
        begin
            hex_val = 4'(character - 8'h57);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // Decimal exponent accumulation, saturating at 2^31.
    always_comb
    begin
        is_dec   = (character >= "0" && character <= "9");
        exp_prod = ({4'd0, st_reg.exp_mag} << 3) + ({4'd0, st_reg.exp_mag} << 1)
                 + {32'd0, hex_val};
        exp_mag_digit = (exp_prod >= {4'd0, hflp_pkg::EXP_SAT}) ? hflp_pkg::EXP_SAT
                                                                : exp_prod[31:0];
    end

    // Next parse state for the incoming character.
    always_comb
    begin
        st_next = st_reg;
        if (character != "_" && !st_reg.error_seen)
        begin
            unique case (st_reg.phase)
                hflp_pkg::PH_START:
                begin
                    if (character == "-" || character == "+")
                    begin
                        st_next.negative = (character == "-");
                        st_next.phase    = hflp_pkg::PH_SIGNED;
                    end
                    else if (character == "0")
                    begin
                        st_next.phase = hflp_pkg::PH_ZERO;
                    end
                    else
                    begin
                        st_next.phase = hflp_pkg::PH_DECIMAL;
                    end
                end
                hflp_pkg::PH_SIGNED:
                begin
                    st_next.phase = (character == "0") ? hflp_pkg::PH_ZERO
                                                       : hflp_pkg::PH_DECIMAL;
                end
                hflp_pkg::PH_ZERO:
                begin
                    st_next.phase = (character == "x" || character == "X")
                                  ? hflp_pkg::PH_MANT : hflp_pkg::PH_DECIMAL;
                end
                hflp_pkg::PH_MANT:
                begin
                    if (character == ".")
                    begin
                        if (st_reg.point_seen)
                        begin
                            st_next.error_seen = 1'b1;
                        end
                        else
                        begin
                            st_next.point_seen = 1'b1;
                            st_next.point_pos  = st_reg.digit_bit_cnt;
                        end
                    end
                    else if (character == "p" || character == "P")
                    begin
                        st_next.phase = hflp_pkg::PH_EXP_START;
                    end
                    else if (!is_hex)
                    begin
                        st_next.error_seen = 1'b1;
                    end
                    else
                    begin
                        st_next.digit_bit_cnt =
                            (st_reg.digit_bit_cnt > hflp_pkg::CNT_MAX - 32'd4)
                            ? hflp_pkg::CNT_MAX : st_reg.digit_bit_cnt + 32'd4;
                        // Leading zero digits add nothing to the mantissa.
                        if (!(hex_val == 4'd0 && st_reg.mantissa == '0))
                        begin
                            if (st_reg.mant_bit_cnt < hflp_pkg::MBC_W'(hflp_pkg::KEEP_BITS))
                            begin
                                st_next.mantissa =
                                    {st_reg.mantissa[hflp_pkg::MANT_W-5:0], hex_val};
                                st_next.mant_bit_cnt = st_reg.mant_bit_cnt + 7'd4;
                            end
                            else
                            begin
                                // Digits past the kept width fold into a sticky bit.
                                st_next.mantissa[0] = st_reg.mantissa[0] | (hex_val != 4'd0);
                                st_next.extra_bit_cnt =
                                    (st_reg.extra_bit_cnt > hflp_pkg::CNT_MAX - 32'd4)
                                    ? hflp_pkg::CNT_MAX : st_reg.extra_bit_cnt + 32'd4;
                            end
                        end
                    end
                end
                hflp_pkg::PH_EXP_START:
                begin
                    if (character == "+" || character == "-")
                    begin
                        st_next.exp_neg = (character == "-");
                        st_next.phase   = hflp_pkg::PH_EXP_SIGNED;
                    end
                    else if (is_dec)
                    begin
                        st_next.exp_mag = exp_mag_digit;
                        st_next.phase   = hflp_pkg::PH_EXP_DIGITS;
                    end
                    else
                    begin
                        st_next.error_seen = 1'b1;
                    end
                end
                hflp_pkg::PH_EXP_SIGNED, hflp_pkg::PH_EXP_DIGITS:
                begin
                    if (is_dec)
                    begin
                        st_next.exp_mag = exp_mag_digit;
                        st_next.phase   = hflp_pkg::PH_EXP_DIGITS;
                    end
                    else
                    begin
                        st_next.error_seen = 1'b1;
                    end
                end
                hflp_pkg::PH_DECIMAL:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    // Parse state register: returns to the start state after the last character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: hflp_pkg::PH_START, negative: 1'b0, mantissa: '0,
                        mant_bit_cnt: '0, digit_bit_cnt: '0, point_seen: 1'b0,
                        point_pos: '0, extra_bit_cnt: '0, exp_mag: '0,
                        exp_neg: 1'b0, error_seen: 1'b0};
        end
        else if (en && in_valid)
        begin
            if (last)
            begin
                st_reg <= '{phase: hflp_pkg::PH_START, negative: 1'b0, mantissa: '0,
                            mant_bit_cnt: '0, digit_bit_cnt: '0, point_seen: 1'b0,
                            point_pos: '0, extra_bit_cnt: '0, exp_mag: '0,
                            exp_neg: 1'b0, error_seen: 1'b0};
            end
            else
            begin
                st_reg <= st_next;
            end
        end
    end

    // Snapshot of the finished literal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            snap_valid_reg <= in_valid && last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid && last)
        begin
            snap_reg <= st_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== rtl/hflp_prep.sv =====
// First conversion stage: status, saturated answers, exponent sum and leading-one search.
`timescale 1ns / 1ps

module hflp_prep
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  hflp_pkg::snap_t   snap,
    output logic              out_valid,
    output hflp_pkg::prep_t   prep
);

    hflp_pkg::prep_t            prep_reg;
    hflp_pkg::prep_t            prep_next;
    logic                       valid_reg;
    logic                       has_exp;
    logic [31:0]                sign_bits;
    logic signed [34:0]         e_mag;
    logic signed [34:0]         e_sum;
    logic [hflp_pkg::MSB_W-1:0] msb;

    // Leading-one index of the mantissa.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < hflp_pkg::MANT_W; i++)
        begin
            if (snap.mantissa[i])
            begin
                msb = hflp_pkg::MSB_W'(i);
            end
        end
    end

    // Exponent plus point and overflow-digit adjustment, clamped to 32 bits.
    always_comb
    begin
        has_exp = (snap.phase == hflp_pkg::PH_EXP_DIGITS);
        e_mag   = $signed({3'b000, snap.exp_mag});
        e_sum   = (has_exp ? (snap.exp_neg ? -e_mag : e_mag) : 35'sd0)
                + $signed({3'b000, snap.extra_bit_cnt})
                + (snap.point_seen ? ($signed({3'b000, snap.point_pos})
                                    - $signed({3'b000, snap.digit_bit_cnt})) : 35'sd0);
    end

    // Status and answers that need no rounding.
    always_comb
    begin
        sign_bits              = {snap.negative, 31'd0};
        prep_next.status       = hflp_pkg::STATUS_OK;
        prep_next.special      = 1'b0;
        prep_next.special_bits = 32'd0;
        prep_next.sign         = snap.negative;
        prep_next.mantissa     = snap.mantissa;
        prep_next.msb          = msb;
        if (e_sum > 35'sd2147483647)
        begin
            prep_next.exponent = 32'sh7FFF_FFFF;
        end
        else if (e_sum < -35'sd2147483648)
        begin
            prep_next.exponent = 32'sh8000_0000;
        end
        else
        begin
            prep_next.exponent = e_sum[31:0];
        end

        if (snap.error_seen || snap.phase == hflp_pkg::PH_START
            || snap.phase == hflp_pkg::PH_EXP_START
            || snap.phase == hflp_pkg::PH_EXP_SIGNED)
        begin
            prep_next.status  = hflp_pkg::STATUS_MALFORMED;
            prep_next.special = 1'b1;
        end
        else if (snap.phase == hflp_pkg::PH_SIGNED || snap.phase == hflp_pkg::PH_ZERO
                 || snap.phase == hflp_pkg::PH_DECIMAL)
        begin
            prep_next.status  = hflp_pkg::STATUS_DECIMAL;
            prep_next.special = 1'b1;
        end
        else if (has_exp && snap.exp_neg && snap.exp_mag >= hflp_pkg::EXP_SAT)
        begin
            // Huge negative exponent: signed zero.
            prep_next.special      = 1'b1;
            prep_next.special_bits = sign_bits;
        end
        else if (has_exp && !snap.exp_neg && snap.exp_mag >= hflp_pkg::EXP_SAT - 32'd1)
        begin
            // Huge positive exponent: signed infinity, or zero for a zero mantissa.
            prep_next.special      = 1'b1;
            prep_next.special_bits = sign_bits
                                   | ((snap.mantissa == '0) ? 32'd0 : hflp_pkg::INF_BITS);
        end
        else if (snap.digit_bit_cnt == 32'd0)
        begin
            prep_next.status  = hflp_pkg::STATUS_MALFORMED;
            prep_next.special = 1'b1;
        end
        else if (snap.mantissa == '0)
        begin
            prep_next.special      = 1'b1;
            prep_next.special_bits = sign_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign out_valid = valid_reg;
    assign prep      = prep_reg;

endmodule

// ===== rtl/hflp_round.sv =====
// Second conversion stage: normalize the mantissa and round it to 24 bits, ties to even.
`timescale 1ns / 1ps

module hflp_round
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  hflp_pkg::prep_t   prep,
    output logic              out_valid,
    output hflp_pkg::rnd_t    rnd
);

    localparam int RW = hflp_pkg::MANT_W - 24;

    hflp_pkg::rnd_t              rnd_reg;
    hflp_pkg::rnd_t              rnd_next;
    logic                        valid_reg;
    logic [hflp_pkg::MSB_W-1:0]  norm_sh;
    logic [hflp_pkg::MANT_W-1:0] norm;
    logic [23:0]                 q0;
    logic                        guard;
    logic                        rest;
    logic                        up;
    logic [24:0]                 qs;

    // Left-justify the leading one, then round off the low bits.
    always_comb
    begin
        norm_sh = hflp_pkg::MSB_W'(hflp_pkg::MANT_W - 1) - prep.msb;
        norm    = prep.mantissa << norm_sh;
        q0      = norm[hflp_pkg::MANT_W-1 -: 24];
        guard   = norm[RW-1];
        rest    = |norm[RW-2:0];
        up      = guard && (rest || q0[0]);
        qs      = {1'b0, q0} + {24'd0, up};

        rnd_next.status       = prep.status;
        rnd_next.special      = prep.special;
        rnd_next.special_bits = prep.special_bits;
        rnd_next.sign         = prep.sign;
        rnd_next.q            = qs[24] ? qs[24:1] : qs[23:0];
        rnd_next.top          = $signed({{2{prep.exponent[31]}}, prep.exponent})
                              + $signed({{(34-hflp_pkg::MSB_W){1'b0}}, prep.msb})
                              + $signed({33'd0, qs[24]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign out_valid = valid_reg;
    assign rnd       = rnd_reg;

endmodule

// ===== rtl/hflp_pack.sv =====
// Last conversion stage: range check, subnormal rounding, packing and the result register.
`timescale 1ns / 1ps

module hflp_pack
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  hflp_pkg::rnd_t    rnd,
    output logic              out_valid,
    output logic [31:0]       value_bits,
    output hflp_pkg::status_t status
);

    logic                      valid_reg;
    logic [31:0]               bits_reg;
    hflp_pkg::status_t         status_reg;
    logic [31:0]               bits_next;
    logic [31:0]               sign_bits;
    logic signed [33:0]        sub_sh;
    logic [4:0]                sh;
    logic [24:0]               qw;
    logic [24:0]               mask;
    logic [24:0]               half;
    logic [24:0]               qq;
    logic [24:0]               rem;
    logic                      up;
    logic [7:0]                bexp;

    always_comb
    begin
        sign_bits = {rnd.sign, 31'd0};
        sub_sh    = -34'sd126 - rnd.top;
        sh        = sub_sh[4:0];
        qw        = {1'b0, rnd.q};
        mask      = (25'd1 << sh) - 25'd1;
        half      = (25'd1 << sh) >> 1;
        qq        = qw >> sh;
        rem       = qw & mask;
        up        = (rem > half) || (rem == half && qq[0]);
        bexp      = 8'(rnd.top + 34'sd127);

        if (rnd.special)
        begin
            bits_next = rnd.special_bits;
        end
        else if (rnd.top > 34'sd127)
        begin
            bits_next = sign_bits | hflp_pkg::INF_BITS;
        end
        else if (rnd.top >= -34'sd126)
        begin
            bits_next = sign_bits | {1'b0, bexp, rnd.q[22:0]};
        end
        else if (sub_sh >= 34'sd25)
        begin
            bits_next = sign_bits;
        end
        else
        begin
            // Subnormal: shift right with nearest-even rounding.
            bits_next = sign_bits | {7'd0, qq} + {31'd0, up};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bits_reg   <= bits_next;
            status_reg <= rnd.status;
        end
    end

    assign out_valid  = valid_reg;
    assign value_bits = bits_reg;
    assign status     = status_reg;

endmodule

// ===== rtl/hex_float_literal_parser.sv =====
// Top level of the hexadecimal binary32 literal parser.
//
// Input channel s_*: one character of the literal per transaction, s_tlast on the
// final character. Output channel m_*: one transaction per literal, carrying the
// binary32 bit pattern in m_tdata and the status in m_tuser (0 ok, 1 malformed,
// 2 decimal form not handled); the pattern is zero when the status is not ok.
// A character is taken in every cycle while the output side keeps up. After the
// transaction that carries s_tlast, the result passes through the register that
// captures the finished parse state and then three conversion stages (exponent
// and leading-one search, normalize and round, range check and pack into the
// result register). The next literal may start in the cycle after s_tlast.
// When m_tready is low while a result waits, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset puts the parser in its start state and empties the pipeline.
`timescale 1ns / 1ps

module hex_float_literal_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // last character of the literal
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_bits
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic              en;
    logic              snap_valid;
    hflp_pkg::snap_t   snap;
    logic              prep_valid;
    hflp_pkg::prep_t   prep;
    logic              rnd_valid;
    hflp_pkg::rnd_t    rnd;
    hflp_pkg::status_t status;

    // The pipeline moves whenever the result register is free or being taken.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tuser  = status;

    hflp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .character  (s_tdata),
        .last       (s_tlast),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    hflp_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (snap_valid),
        .snap      (snap),
        .out_valid (prep_valid),
        .prep      (prep)
    );

    hflp_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .prep      (prep),
        .out_valid (rnd_valid),
        .rnd       (rnd)
    );

    hflp_pack u_pack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (rnd_valid),
        .rnd        (rnd),
        .out_valid  (m_tvalid),
        .value_bits (m_tdata),
        .status     (status)
    );

    // A failed literal always carries an all-zero pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status != hflp_pkg::STATUS_OK |-> m_tdata == 32'd0)
    else $error("nonzero value with error status");

    // The unused status code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
    else $error("invalid status code");

    // A character accepted with s_tlast reaches the snapshot stage next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> snap_valid)
    else $error("finished literal not captured");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the hexadecimal binary32 literal parser.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    typedef struct {
        logic [31:0] bits;
        logic [1:0]  status;
    } parse_result_t;

    typedef struct {
        string       text;
        bit          known;
        logic [31:0] bits;
        logic [1:0]  status;
    } literal_row_t;

    parse_result_t  pending_results[$];
    byte unsigned   literal_text[$];
    literal_row_t   literal_rows[];
    int             error_count;
    int             chars_sent;
    int             literals_sent;
    int             results_checked;
    int             idle_cycles;
    bit             no_gaps;

    // Shadow of the parse state.
    hflp_pkg::phase_t sh_phase;
    bit             sh_negative;
    logic [63:0]    sh_mantissa;
    int             sh_mant_bits;
    logic [31:0]    sh_digit_bits;
    bit             sh_point_seen;
    logic [31:0]    sh_point_pos;
    logic [31:0]    sh_extra_bits;
    logic [31:0]    sh_exp_mag;
    bit             sh_exp_neg;
    bit             sh_error;

    hex_float_literal_parser u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void clear_parse_state();
        sh_phase      = hflp_pkg::PH_START;
        sh_negative   = 1'b0;
        sh_mantissa   = '0;
        sh_mant_bits  = 0;
        sh_digit_bits = '0;
        sh_point_seen = 1'b0;
        sh_point_pos  = '0;
        sh_extra_bits = '0;
        sh_exp_mag    = '0;
        sh_exp_neg    = 1'b0;
        sh_error      = 1'b0;
    endfunction

    function automatic logic [31:0] add_nibble_count(logic [31:0] v);
        return (v > 32'hFFFF_FFFB) ? hflp_pkg::CNT_MAX : v + 32'd4;
    endfunction

    function automatic int hex_digit_value(byte unsigned c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic int top_bit(logic [63:0] v);
        for (int i = 63; i >= 0; i--)
            if (v[i]) return i;
        return -1;
    endfunction

    // Shift right with round to nearest, ties to even.
    function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >> sh;
        rem  = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    // Round the kept mantissa to single precision and scale by the exponent.
    function automatic logic [31:0] pack_single(logic [63:0] m, longint scale, bit neg);
        logic [31:0] sign;
        logic [63:0] q;
        longint      shift;
        longint      e;
        longint      top;
        longint      s;
        int          b;
        int          qb;
        sign  = neg ? 32'h8000_0000 : 32'h0;
        q     = m;
        shift = 0;
        if (m == 0) return sign;
        b = top_bit(m);
        if (b > 23)
        begin
            q     = round_shift(m, b - 23);
            shift = b - 23;
            if (q >> 24 != 0)
            begin
                q     = q >> 1;
                shift = shift + 1;
            end
        end
        qb  = top_bit(q);
        e   = shift + scale;
        top = qb + e;
        if (top > 127) return sign | hflp_pkg::INF_BITS;
        if (top >= -126)
            return sign | (32'(top + 127) << 23) | (32'(q << (23 - qb)) & 32'h7F_FFFF);
        s = e + 149;
        if (s >= 0) return sign | 32'(q << s);
        if (-s > 25) return sign;
        return sign | 32'(round_shift(q, int'(-s)));
    endfunction

    // Advance the shadow parse state by one character.
    function automatic void parse_char(byte unsigned c);
        int     d;
        longint v;
        if (sh_error || c == "_") return;
        case (sh_phase)
            hflp_pkg::PH_START:
                if (c == "-" || c == "+")
                begin
                    sh_negative = (c == "-");
                    sh_phase    = hflp_pkg::PH_SIGNED;
                end
                else sh_phase = (c == "0") ? hflp_pkg::PH_ZERO : hflp_pkg::PH_DECIMAL;
            hflp_pkg::PH_SIGNED:
                sh_phase = (c == "0") ? hflp_pkg::PH_ZERO : hflp_pkg::PH_DECIMAL;
            hflp_pkg::PH_ZERO:
                sh_phase = (c == "x" || c == "X") ? hflp_pkg::PH_MANT
                                                  : hflp_pkg::PH_DECIMAL;
            hflp_pkg::PH_MANT:
            begin
                d = hex_digit_value(c);
                if (c == ".")
                begin
                    if (sh_point_seen) sh_error = 1'b1;
                    else
                    begin
                        sh_point_seen = 1'b1;
                        sh_point_pos  = sh_digit_bits;
                    end
                end
                else if (c == "p" || c == "P") sh_phase = hflp_pkg::PH_EXP_START;
                else if (d < 0) sh_error = 1'b1;
                else
                begin
                    sh_digit_bits = add_nibble_count(sh_digit_bits);
                    if (!(d == 0 && sh_mantissa == 0))
                    begin
                        if (sh_mant_bits < hflp_pkg::KEEP_BITS)
                        begin
                            sh_mantissa  = (sh_mantissa << 4) + 64'(d);
                            sh_mant_bits = sh_mant_bits + 4;
                        end
                        else
                        begin
                            if (d != 0) sh_mantissa[0] = 1'b1;
                            sh_extra_bits = add_nibble_count(sh_extra_bits);
                        end
                    end
                end
            end
            hflp_pkg::PH_EXP_START, hflp_pkg::PH_EXP_SIGNED, hflp_pkg::PH_EXP_DIGITS:
            begin
                if (sh_phase == hflp_pkg::PH_EXP_START && (c == "+" || c == "-"))
                begin
                    sh_exp_neg = (c == "-");
                    sh_phase   = hflp_pkg::PH_EXP_SIGNED;
                end
                else if (c >= "0" && c <= "9")
                begin
                    v = longint'(sh_exp_mag) * 10 + (c - "0");
                    sh_exp_mag = (v >= longint'(hflp_pkg::EXP_SAT)) ? hflp_pkg::EXP_SAT
                                                                    : 32'(v);
                    sh_phase   = hflp_pkg::PH_EXP_DIGITS;
                end
                else sh_error = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Result of the literal that ends with the current character.
    function automatic parse_result_t finish_literal();
        parse_result_t r;
        logic [31:0]   sign;
        bit            has_exp;
        longint        scale;
        r.bits   = '0;
        r.status = hflp_pkg::STATUS_OK;
        sign     = sh_negative ? 32'h8000_0000 : 32'h0;
        has_exp  = (sh_phase == hflp_pkg::PH_EXP_DIGITS);
        if (sh_error || sh_phase == hflp_pkg::PH_START
            || sh_phase == hflp_pkg::PH_EXP_START
            || sh_phase == hflp_pkg::PH_EXP_SIGNED)
            r.status = hflp_pkg::STATUS_MALFORMED;
        else if (sh_phase == hflp_pkg::PH_SIGNED || sh_phase == hflp_pkg::PH_ZERO
                 || sh_phase == hflp_pkg::PH_DECIMAL)
            r.status = hflp_pkg::STATUS_DECIMAL;
        else if (has_exp && sh_exp_neg && sh_exp_mag >= hflp_pkg::EXP_SAT)
            r.bits = sign;
        else if (has_exp && !sh_exp_neg && sh_exp_mag >= hflp_pkg::EXP_SAT - 32'd1)
            r.bits = sign | ((sh_mantissa == 0) ? 32'h0 : hflp_pkg::INF_BITS);
        else if (sh_digit_bits == 0)
            r.status = hflp_pkg::STATUS_MALFORMED;
        else
        begin
            scale = has_exp ? longint'(sh_exp_mag) : 0;
            if (has_exp && sh_exp_neg) scale = -scale;
            scale = scale + longint'(sh_extra_bits);
            if (sh_point_seen)
                scale = scale + longint'(sh_point_pos) - longint'(sh_digit_bits);
            if (scale > 64'sd2147483647) scale = 64'sd2147483647;
            if (scale < -64'sd2147483648) scale = -64'sd2147483648;
            r.bits = pack_single(sh_mantissa, scale, sh_negative);
        end
        clear_parse_state();
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int idle_length();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Send the literal in literal_text; expected result is typed or predicted.
    task automatic send_literal(bit known, logic [31:0] bits, logic [1:0] status);
        parse_result_t r;
        int            gap;
        for (int i = 0; i < literal_text.size(); i++)
        begin
            gap = idle_length();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= literal_text[i];
            s_tlast  <= (i == literal_text.size() - 1);
            do @(posedge clk); while (!s_tready);
            chars_sent++;
            parse_char(literal_text[i]);
        end
        r = finish_literal();
        if (known)
        begin
            r.bits   = bits;
            r.status = status;
        end
        pending_results.push_back(r);
        literals_sent++;
    endtask

    function automatic byte unsigned random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    // Build one random literal: mostly well formed, some noise or broken text.
    function automatic void build_random_literal();
        int n;
        int point_at;
        literal_text.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) literal_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 3))
            0: literal_text.push_back("-");
            1: literal_text.push_back("+");
            default: ;
        endcase
        literal_text.push_back("0");
        literal_text.push_back($urandom_range(0, 1) ? "x" : "X");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 9);
        point_at = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, n);
        for (int i = 0; i <= n; i++)
        begin
            if (i == point_at) literal_text.push_back(".");
            if (i < n)
                literal_text.push_back(($urandom_range(0, 3) == 0) ? "0" : random_hex_char());
            if ($urandom_range(0, 19) == 0) literal_text.push_back("_");
        end
        if ($urandom_range(0, 2) != 0)
        begin
            literal_text.push_back($urandom_range(0, 1) ? "p" : "P");
            case ($urandom_range(0, 2))
                0: literal_text.push_back("-");
                1: literal_text.push_back("+");
                default: ;
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
            repeat (n) literal_text.push_back(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0)
            literal_text[$urandom_range(0, literal_text.size() - 1)] =
                8'($urandom_range(0, 255));
    endfunction

    // Result side: random back pressure and comparison with the predictions.
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: value_bits %h status %0d",
                       m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata !== want.bits)
                begin
                    $error("value_bits: expected %h, actual %h", want.bits, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
            end
        end
        m_tready <= no_gaps ? 1'b1 : (idle_length() == 0);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Stalled after %0d characters in %0d literals; checked %0d results.",
                     chars_sent, literals_sent, results_checked);
            $display("[hex_float_literal_parser] ERROR");
            $finish;
        end
    end

    // Stimulus: directed literals first, then random literals.
    initial
    begin
        literal_rows = '{
            '{"_",                    1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1",                  1'b1, 32'h3F80_0000, hflp_pkg::STATUS_OK},
            '{"-0x1p-1",              1'b1, 32'hBF00_0000, hflp_pkg::STATUS_OK},
            '{"0X1.8P+1",             1'b1, 32'h4040_0000, hflp_pkg::STATUS_OK},
            '{"0x1p128",              1'b1, 32'h7F80_0000, hflp_pkg::STATUS_OK},
            '{"0x1p-149",             1'b1, 32'h0000_0001, hflp_pkg::STATUS_OK},
            '{"0x1p-150",             1'b1, 32'h0000_0000, hflp_pkg::STATUS_OK},
            '{"0x1p2147483647",       1'b1, 32'h7F80_0000, hflp_pkg::STATUS_OK},
            '{"-0x0p99999999999",     1'b1, 32'h8000_0000, hflp_pkg::STATUS_OK},
            '{"0x1p-2147483648",      1'b1, 32'h0000_0000, hflp_pkg::STATUS_OK},
            '{"0xp-9999999999",       1'b1, 32'h0000_0000, hflp_pkg::STATUS_OK},
            '{"12",                   1'b1, 32'h0000_0000, hflp_pkg::STATUS_DECIMAL},
            '{"+",                    1'b1, 32'h0000_0000, hflp_pkg::STATUS_DECIMAL},
            '{"0",                    1'b1, 32'h0000_0000, hflp_pkg::STATUS_DECIMAL},
            '{"0y",                   1'b1, 32'h0000_0000, hflp_pkg::STATUS_DECIMAL},
            '{"0x1g",                 1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1..2",               1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1p",                 1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1p+",                1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1p 3",               1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x",                   1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1p3x",               1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0x1\xff",              1'b1, 32'h0000_0000, hflp_pkg::STATUS_MALFORMED},
            '{"0xFFFFFFFFFFFFFFFFFFF1", 1'b0, 32'h0, hflp_pkg::STATUS_OK},
            '{"0x_a.b_cdEf_p-1_0",    1'b0, 32'h0, hflp_pkg::STATUS_OK},
            '{"-0x1.fffffffp127",     1'b0, 32'h0, hflp_pkg::STATUS_OK}
        };
        error_count     = 0;
        chars_sent      = 0;
        literals_sent   = 0;
        results_checked = 0;
        idle_cycles     = 0;
        no_gaps         = 1'b0;
        clear_parse_state();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (literal_rows[i])
        begin
            literal_text.delete();
            for (int k = 0; k < literal_rows[i].text.len(); k++)
                literal_text.push_back(literal_rows[i].text[k]);
            send_literal(literal_rows[i].known, literal_rows[i].bits,
                         literal_rows[i].status);
        end

        while (chars_sent < 1500 || literals_sent < 80)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            build_random_literal();
            send_literal(1'b0, 32'h0, hflp_pkg::STATUS_OK);
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d characters in %0d literals; checked %0d results.",
                 chars_sent, literals_sent, results_checked);
        if (error_count == 0)
            $display("[hex_float_literal_parser] OK");
        else
            $display("[hex_float_literal_parser] ERROR");
        $finish;
    end

endmodule
